// ===== sv/tmf_pkg.sv =====
// Package with shared constants and control types for the trimmed-mean pH filter.
`timescale 1ns / 1ps

package tmf_pkg;

    localparam int unsigned SampleW  = 10;
    localparam int unsigned ChanW    = 2;
    localparam int unsigned CalW     = 12;
    localparam int unsigned PhW      = 13;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned FillW    = 4;
    localparam int unsigned SumW     = 14;
    localparam int unsigned TrimW    = 13;
    localparam int unsigned ProdW    = 22;
    localparam int unsigned ScaleSh  = 10;

    // Index of the last sample of a block of ten.
    localparam logic [FillW-1:0] LastIdx = 4'd9;

    localparam logic [ProdW-1:0] ScaleNum  = 22'd475;
    localparam logic [ProdW-1:0] RoundHalf = 22'd512;

    localparam logic [CalW-1:0] CalResetCh0 = 12'd2384;
    localparam logic [CalW-1:0] CalResetCh1 = 12'd2444;
    localparam logic [CalW-1:0] CalResetCh2 = 12'd2514;

    localparam logic [CfgIdxW-1:0] CFG_CAL_CH0 = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_CAL_CH1 = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_CAL_CH2 = 2'd2;

    localparam logic [ChanW-1:0] CH_PROBE0 = 2'd0;
    localparam logic [ChanW-1:0] CH_PROBE1 = 2'd1;
    localparam logic [ChanW-1:0] CH_PROBE2 = 2'd2;

    typedef struct packed {
        logic load;      // take the sample of an input transaction
        logic trim;      // form the trimmed sum
        logic mult;      // scale the trimmed sum
        logic out_load;  // write the result register
    } tmf_cmd_t;

    typedef struct packed {
        logic last;      // the next sample completes a block
    } tmf_status_t;

endpackage

// ===== sv/ph_trimmed_mean_filter.sv =====
// Top level of the trimmed-mean pH filter over blocks of ten samples.
//
//   Channel  Signals                          Content
//   input    in_valid / in_ready              sample, channel
//   output   out_valid / out_ready            ph_centi, ch_out
//   config   cfg_valid / cfg_ready            cfg_index, cfg_data
//
// Each sample transaction is taken in the idle state; the tenth of a block is
// followed by trim, multiply and result load, set by the controller sequence.
// Reset clears the fill count and the result flag and restores the offsets.
// The result register holds a finished result while nine further samples are
// taken; only a block-completing sample stalls until that result is read.
`timescale 1ns / 1ps

module ph_trimmed_mean_filter
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tmf_pkg::SampleW-1:0]         sample,
    input  logic [tmf_pkg::ChanW-1:0]           channel,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [tmf_pkg::PhW-1:0]      ph_centi,
    output logic [tmf_pkg::ChanW-1:0]           ch_out,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tmf_pkg::CfgIdxW-1:0]         cfg_index,
    input  logic [tmf_pkg::CalW-1:0]            cfg_data
);

    tmf_pkg::tmf_cmd_t    cmd;
    tmf_pkg::tmf_status_t status;

    assign cfg_ready = 1'b1;

    tmf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tmf_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .channel   (channel),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .ph_centi  (ph_centi),
        .ch_out    (ch_out)
    );

`ifndef SYNTHESIS
    a_trim_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.trim |-> $past(in_valid && in_ready && status.last))
        else $error("trim step without a completing sample");

    a_mult_follows_trim: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.trim |=> cmd.mult)
        else $error("multiply step did not follow trim step");

    a_load_follows_mult: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mult |=> cmd.out_load)
        else $error("result load did not follow multiply step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid)
        else $error("result register overwritten before it was read");
`endif

endmodule

// ===== sv/tmf_ctrl.sv =====
// Controller state machine of the trimmed-mean pH filter.
`timescale 1ns / 1ps

module tmf_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  tmf_pkg::tmf_status_t status,
    output tmf_pkg::tmf_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_TRIM = 4'b0010,
        S_MULT = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    // A block-completing sample is held off while the previous result is still unread.
    assign in_ready  = (state_reg == S_IDLE) && !(status.last && out_valid_reg);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    if (status.last)
                    begin
                        state_next = S_TRIM;
                    end
                end
            end
            S_TRIM:
            begin
                cmd.trim   = 1'b1;
                state_next = S_MULT;
            end
            S_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.out_load   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/tmf_datapath.sv =====
// Datapath of the trimmed-mean pH filter: running extremes, sum, scaling and offsets.
`timescale 1ns / 1ps

module tmf_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [tmf_pkg::SampleW-1:0]         sample,
    input  logic [tmf_pkg::ChanW-1:0]           channel,
    input  logic                                cfg_we,
    input  logic [tmf_pkg::CfgIdxW-1:0]         cfg_index,
    input  logic [tmf_pkg::CalW-1:0]            cfg_data,
    input  tmf_pkg::tmf_cmd_t                   cmd,
    output tmf_pkg::tmf_status_t                status,
    output logic signed [tmf_pkg::PhW-1:0]      ph_centi,
    output logic [tmf_pkg::ChanW-1:0]           ch_out
);

    logic [tmf_pkg::FillW-1:0]   fill_reg;
    logic [tmf_pkg::FillW-1:0]   fill_next;
    logic [tmf_pkg::CalW-1:0]    cal0_reg;
    logic [tmf_pkg::CalW-1:0]    cal1_reg;
    logic [tmf_pkg::CalW-1:0]    cal2_reg;

    logic [tmf_pkg::SumW-1:0]    sum_reg;
    logic [tmf_pkg::SumW-1:0]    sum_next;
    logic [tmf_pkg::SampleW-1:0] min1_reg, min2_reg, max1_reg, max2_reg;
    logic [tmf_pkg::SampleW-1:0] min1_next, min2_next, max1_next, max2_next;
    logic [tmf_pkg::ChanW-1:0]   ch_reg;
    logic [tmf_pkg::TrimW-1:0]   trim_reg;
    logic [tmf_pkg::SumW-1:0]    trim_next;
    logic [tmf_pkg::ProdW-1:0]   prod_reg;
    logic [tmf_pkg::ProdW-1:0]   prod_next;
    logic [tmf_pkg::CalW-1:0]    cal_sel;
    logic [tmf_pkg::PhW-1:0]     ph_next;
    logic [tmf_pkg::PhW-1:0]     ph_reg;
    logic [tmf_pkg::ChanW-1:0]   ch_out_reg;

    assign status.last = (fill_reg == tmf_pkg::LastIdx);
    assign fill_next   = status.last ? '0 : fill_reg + 4'd1;

    // The middle six of ten sorted samples are the total less the two lowest
    // and the two highest, so only those four extremes are tracked per sample.
    always_comb
    begin
        min1_next = min1_reg;
        min2_next = min2_reg;
        max1_next = max1_reg;
        max2_next = max2_reg;
        if (fill_reg == '0)
        begin
            sum_next  = tmf_pkg::SumW'(sample);
            min1_next = sample;
            min2_next = '1;
            max1_next = sample;
            max2_next = '0;
        end
        else
        begin
            sum_next = sum_reg + tmf_pkg::SumW'(sample);
            if (sample < min1_reg)
            begin
                min2_next = min1_reg;
                min1_next = sample;
            end
            else if (sample < min2_reg)
            begin
                min2_next = sample;
            end
            if (sample > max1_reg)
            begin
                max2_next = max1_reg;
                max1_next = sample;
            end
            else if (sample > max2_reg)
            begin
                max2_next = sample;
            end
        end
    end

    assign trim_next = sum_reg - tmf_pkg::SumW'(min1_reg) - tmf_pkg::SumW'(min2_reg)
                     - tmf_pkg::SumW'(max1_reg) - tmf_pkg::SumW'(max2_reg);

    assign prod_next = tmf_pkg::ProdW'(trim_reg) * tmf_pkg::ScaleNum + tmf_pkg::RoundHalf;

    always_comb
    begin
        case (ch_reg)
            tmf_pkg::CH_PROBE0: cal_sel = cal0_reg;
            tmf_pkg::CH_PROBE1: cal_sel = cal1_reg;
            tmf_pkg::CH_PROBE2: cal_sel = cal2_reg;
            default:            cal_sel = '0;
        endcase
    end

    assign ph_next = tmf_pkg::PhW'(cal_sel)
                   - tmf_pkg::PhW'(prod_reg[tmf_pkg::ProdW-1:tmf_pkg::ScaleSh]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            cal0_reg <= tmf_pkg::CalResetCh0;
            cal1_reg <= tmf_pkg::CalResetCh1;
            cal2_reg <= tmf_pkg::CalResetCh2;
        end
        else
        begin
            if (cmd.load)
            begin
                fill_reg <= fill_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    tmf_pkg::CFG_CAL_CH0: cal0_reg <= cfg_data;
                    tmf_pkg::CFG_CAL_CH1: cal1_reg <= cfg_data;
                    tmf_pkg::CFG_CAL_CH2: cal2_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sum_reg  <= sum_next;
            min1_reg <= min1_next;
            min2_reg <= min2_next;
            max1_reg <= max1_next;
            max2_reg <= max2_next;
            ch_reg   <= channel;
        end
        if (cmd.trim)
        begin
            trim_reg <= trim_next[tmf_pkg::TrimW-1:0];
        end
        if (cmd.mult)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.out_load)
        begin
            ph_reg     <= ph_next;
            ch_out_reg <= ch_reg;
        end
    end

    assign ph_centi = ph_reg;
    assign ch_out   = ch_out_reg;

endmodule
